// ===== rtl/lvfd_pkg.sv =====
// Package for the local variance fractal dimension block.
// Beat types, fixed widths and register indexes; no dependencies.
package lvfd_pkg;

  localparam int CH_W     = 8;
  localparam int COORD_W  = 10;
  localparam int RAD_W    = 7;
  localparam int LOG_IN_W = 16;
  localparam int LOG_W    = 20;
  localparam int DIVD_W   = 34;
  localparam int DIVS_W   = 22;
  localparam int PIX_W    = 3 * CH_W;

  localparam logic [1:0] REG_SMALL_RADIUS = 2'd0;
  localparam logic [1:0] REG_LARGE_RADIUS = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [7:0]      col;
    logic [7:0]      row;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic signed [15:0] dim_red;
    logic signed [15:0] dim_green;
    logic signed [15:0] dim_blue;
    logic               undef_red;
    logic               undef_green;
    logic               undef_blue;
  } result_t;

endpackage

// ===== rtl/lvfd_store.sv =====
// Pixel store: one write port, one read port, registered read data.
// Depends on lvfd_pkg.
module lvfd_store import lvfd_pkg::*; #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lvfd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lvfd_pkg.
module lvfd_div import lvfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVS_W:0]   rem;
  logic [DIVS_W-1:0] dsr;
  logic [5:0]        step;
  logic [DIVS_W:0]   shifted;

  assign shifted = {rem[DIVS_W-1:0], quotient[DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy     <= 1'b1;
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        step     <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          rem      <= shifted - {1'b0, dsr};
          quotient <= {quotient[DIVD_W-2:0], 1'b1};
        end else begin
          rem      <= shifted;
          quotient <= {quotient[DIVD_W-2:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lvfd_log2.sv =====
// Base-2 logarithm in unsigned Q.16 by normalize and repeated squaring.
// Depends on lvfd_pkg.
module lvfd_log2 import lvfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [LOG_IN_W-1:0] x,
  output logic                done,
  output logic [LOG_W-1:0]    result
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_ACC  = 2'd3;

  logic [1:0]  state;
  logic [31:0] m;
  logic [63:0] prod;
  logic [3:0]  n;
  logic [15:0] frac;
  logic [3:0]  bitc;
  logic [32:0] sq;

  assign sq     = prod[63:31];
  assign result = {n, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            m     <= {(x == '0) ? 16'd1 : x, 16'd0};
            n     <= 4'd15;
            frac  <= '0;
            bitc  <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (m[31]) begin
            state <= L_MUL;
          end else begin
            m <= {m[30:0], 1'b0};
            n <= n - 4'd1;
          end
        end
        L_MUL: begin
          prod  <= m * m;
          state <= L_ACC;
        end
        L_ACC: begin
          if (sq[32]) begin
            m    <= sq[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= sq[31:0];
            frac <= {frac[14:0], 1'b0};
          end
          bitc <= bitc + 4'd1;
          if (bitc == 4'd15) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            state <= L_MUL;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/local_variance_fractal_dimension.sv =====
// Top level of the local variance fractal dimension block: sequencer and config.
// Depends on lvfd_pkg, lvfd_store, lvfd_div and lvfd_log2.
//
// Write beats are taken back to back while the block is idle. A query beat
// occupies the block, with item_stall high, until its result is loaded: each
// window (at most 1024 pixels at the largest radius) is scanned twice through
// the single read port of the pixel store, then up to fifteen divisions share
// one bit-serial divider and eight logarithms share one squaring unit. A
// finished result waits in an output register.
module local_variance_fractal_dimension import lvfd_pkg::*; #(
  parameter int IMG_W      = 256,
  parameter int IMG_H      = 256,
  parameter int MAX_RADIUS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int DEPTH  = IMG_W * IMG_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 1);
  localparam int CNT_W  = 2 * SPAN_W;
  localparam int ACC_W  = 2 * CH_W + CNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WIN   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_DIVGO = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_LOGGO = 4'd6;
  localparam logic [3:0] S_LOGW  = 4'd7;
  localparam logic [3:0] S_QGO   = 4'd8;
  localparam logic [3:0] S_QW    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [4:0] small_radius, large_radius;
  logic [8:0] image_width, image_height;

  logic [3:0] state;
  logic       win, pass;
  logic [1:0] ch;
  logic [2:0] lj;
  logic [7:0] col_q, row_q;
  logic [COORD_W-1:0] x0, x1, y0, y1, x, y;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-1:0]   acc [3];
  logic [CH_W-1:0]    mean [3];
  logic [LOG_IN_W-1:0] var_s [3];
  logic [LOG_IN_W-1:0] var_l [3];
  logic [LOG_W-1:0]   log_d1, log_d2;
  logic [LOG_W-1:0]   log_v1 [3];
  logic [LOG_W-1:0]   log_v2 [3];
  logic signed [15:0] dim [3];
  logic               undef [3];
  logic               rvalid;

  logic [8:0]         w_c, h_c;
  logic [RAD_W-1:0]   rad_s, rad_l, rad;
  logic [COORD_W-1:0] c_e, r_e, rad_e, xe, ye, wx0, wx1, wy0, wy1;
  logic               accept, outside, out_free;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [PIX_W-1:0]    rdata;
  logic [ACC_W-1:0]    lane_add [3];

  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quo;
  logic [DIVS_W-1:0] div_divisor;

  logic                log_start, log_done;
  logic [LOG_IN_W-1:0] log_x;
  logic [LOG_W-1:0]    log_res;

  logic signed [LOG_W:0] den, num;
  logic [LOG_W-1:0]      abs_den, abs_num;
  logic                  q_neg, q_skip;
  logic signed [15:0]    q_sat;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_radius <= 5'd2;
      large_radius <= 5'd8;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMALL_RADIUS: small_radius <= cfg_data[4:0];
        REG_LARGE_RADIUS: large_radius <= cfg_data[4:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (image_width == '0) ? 9'd1 :
          ((32'(image_width) > IMG_W) ? 9'(IMG_W) : image_width);
    h_c = (image_height == '0) ? 9'd1 :
          ((32'(image_height) > IMG_H) ? 9'(IMG_H) : image_height);
    rad_s = (small_radius == '0) ? RAD_W'(1) :
            ((32'(small_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(small_radius));
    rad_l = (large_radius == '0) ? RAD_W'(1) :
            ((32'(large_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(large_radius));
    rad   = win ? rad_l : rad_s;
    c_e   = COORD_W'(col_q);
    r_e   = COORD_W'(row_q);
    rad_e = COORD_W'(rad);
    xe    = c_e + rad_e;
    ye    = r_e + rad_e;
    wx0   = (c_e > rad_e) ? c_e - rad_e : '0;
    wy0   = (r_e > rad_e) ? r_e - rad_e : '0;
    wx1   = (xe < COORD_W'(w_c)) ? xe : COORD_W'(w_c);
    wy1   = (ye < COORD_W'(h_c)) ? ye : COORD_W'(h_c);
    outside = ({1'b0, item.col} >= w_c) || ({1'b0, item.row} >= h_c);
  end

  assign we    = accept && (item.mode == MODE_WRITE) &&
                 (32'(item.col) < IMG_W) && (32'(item.row) < IMG_H);
  assign waddr = ADDR_W'(32'(item.row) * 32'(IMG_W) + 32'(item.col));
  assign raddr = ADDR_W'(32'(y) * 32'(IMG_W) + 32'(x));

  lvfd_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({item.red, item.green, item.blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [CH_W-1:0]    v;
      logic signed [CH_W:0] d;
      logic signed [2*CH_W+1:0] sq;
      v  = rdata[PIX_W-1-CH_W*k -: CH_W];
      d  = $signed({1'b0, v}) - $signed({1'b0, mean[k]});
      sq = d * d;
      lane_add[k] = pass ? ACC_W'(sq[2*CH_W-1:0]) : ACC_W'(v);
    end
  end

  always_comb begin
    den     = $signed({1'b0, log_d2}) - $signed({1'b0, log_d1});
    num     = $signed({1'b0, log_v2[ch]}) - $signed({1'b0, log_v1[ch]});
    abs_den = den[LOG_W] ? LOG_W'(-den) : den[LOG_W-1:0];
    abs_num = num[LOG_W] ? LOG_W'(-num) : num[LOG_W-1:0];
    q_neg   = num[LOG_W] ^ den[LOG_W];
    q_skip  = (den == '0) || (var_s[ch] == '0) || (var_l[ch] == '0);
    if (q_neg) begin
      q_sat = (div_quo > DIVD_W'(32768)) ? 16'sh8000 : 16'(-div_quo);
    end else begin
      q_sat = (div_quo > DIVD_W'(32767)) ? 16'sh7fff : 16'(div_quo);
    end
  end

  always_comb begin
    if (state == S_QGO) begin
      div_dividend = DIVD_W'({abs_num, 12'd0});
      div_divisor  = DIVS_W'(abs_den);
    end else begin
      div_dividend = DIVD_W'(acc[ch]);
      div_divisor  = DIVS_W'(cnt);
    end
    div_start = (state == S_DIVGO) || ((state == S_QGO) && !q_skip);
  end

  lvfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    unique case (lj)
      3'd0: log_x = LOG_IN_W'(rad_s);
      3'd1: log_x = LOG_IN_W'(rad_l);
      3'd2: log_x = var_s[0];
      3'd3: log_x = var_s[1];
      3'd4: log_x = var_s[2];
      3'd5: log_x = var_l[0];
      3'd6: log_x = var_l[1];
      3'd7: log_x = var_l[2];
      default: log_x = '0;
    endcase
    log_start = (state == S_LOGGO);
  end

  lvfd_log2 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rvalid <= 1'b0;
    end else begin
      rvalid <= (state == S_SCAN);
      if (rvalid) begin
        for (int k = 0; k < 3; k++) begin
          acc[k] <= acc[k] + lane_add[k];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.mode == MODE_QUERY) begin
            col_q <= item.col;
            row_q <= item.row;
            if (outside) begin
              for (int k = 0; k < 3; k++) begin
                dim[k]   <= '0;
                undef[k] <= 1'b1;
              end
              state <= S_OUT;
            end else begin
              win   <= 1'b0;
              state <= S_WIN;
            end
          end
        end
        S_WIN: begin
          x0   <= wx0;
          x1   <= wx1;
          y0   <= wy0;
          y1   <= wy1;
          x    <= wx0;
          y    <= wy0;
          cnt  <= CNT_W'(SPAN_W'(wx1 - wx0)) * CNT_W'(SPAN_W'(wy1 - wy0));
          pass <= 1'b0;
          for (int k = 0; k < 3; k++) acc[k] <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (x == x1 - COORD_W'(1)) begin
            x <= x0;
            if (y == y1 - COORD_W'(1)) begin
              state <= S_DRAIN;
            end else begin
              y <= y + COORD_W'(1);
            end
          end else begin
            x <= x + COORD_W'(1);
          end
        end
        S_DRAIN: begin
          ch    <= '0;
          state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            if (!pass) begin
              mean[ch] <= div_quo[CH_W-1:0];
            end else if (!win) begin
              var_s[ch] <= div_quo[LOG_IN_W-1:0];
            end else begin
              var_l[ch] <= div_quo[LOG_IN_W-1:0];
            end
            if (ch != 2'd2) begin
              ch    <= ch + 2'd1;
              state <= S_DIVGO;
            end else if (!pass) begin
              pass <= 1'b1;
              x    <= x0;
              y    <= y0;
              for (int k = 0; k < 3; k++) acc[k] <= '0;
              state <= S_SCAN;
            end else if (!win) begin
              win   <= 1'b1;
              state <= S_WIN;
            end else begin
              lj    <= '0;
              state <= S_LOGGO;
            end
          end
        end
        S_LOGGO: state <= S_LOGW;
        S_LOGW: begin
          if (log_done) begin
            unique case (lj)
              3'd0: log_d1    <= log_res;
              3'd1: log_d2    <= log_res;
              3'd2: log_v1[0] <= log_res;
              3'd3: log_v1[1] <= log_res;
              3'd4: log_v1[2] <= log_res;
              3'd5: log_v2[0] <= log_res;
              3'd6: log_v2[1] <= log_res;
              3'd7: log_v2[2] <= log_res;
              default: ;
            endcase
            if (lj == 3'd7) begin
              ch    <= '0;
              state <= S_QGO;
            end else begin
              lj    <= lj + 3'd1;
              state <= S_LOGGO;
            end
          end
        end
        S_QGO: begin
          if (q_skip) begin
            dim[ch]   <= '0;
            undef[ch] <= 1'b1;
            if (ch == 2'd2) begin
              state <= S_OUT;
            end else begin
              ch <= ch + 2'd1;
            end
          end else begin
            state <= S_QW;
          end
        end
        S_QW: begin
          if (div_done) begin
            dim[ch]   <= q_sat;
            undef[ch] <= 1'b0;
            if (ch == 2'd2) begin
              state <= S_OUT;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_QGO;
            end
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_valid      <= 1'b1;
      result.dim_red     <= dim[0];
      result.dim_green   <= dim[1];
      result.dim_blue    <= dim[2];
      result.undef_red   <= undef[0];
      result.undef_green <= undef[1];
      result.undef_blue  <= undef[2];
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("pixel read returned outside a scan");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> result_valid && state == S_IDLE)
    else $error("finished query not presented");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DIVW || state == S_LOGW) |-> item_stall)
    else $error("item taken during a query");

endmodule

// ===== tb/sv/local_variance_fractal_dimension_tb.sv =====
// Testbench for local_variance_fractal_dimension: writes pixels, queries the
// local variance dimension and checks each result beat against a predictor.
// Depends on lvfd_pkg and the block under test.
module local_variance_fractal_dimension_tb;
  import lvfd_pkg::*;

  localparam int STORE_W    = 256;
  localparam int STORE_H    = 256;
  localparam int RADIUS_MAX = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 20000;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       result_valid;
  logic       result_stall;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  local_variance_fractal_dimension i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [23:0] pixels [0:STORE_W*STORE_H-1];
  bit          pixel_set [0:STORE_W*STORE_H-1];
  logic [4:0]  small_rad, large_rad;
  logic [8:0]  img_w, img_h;
  result_t     pending_dims [$];

  int  errors;
  int  cycles;
  bit  calm;
  int  hold_ticket, hold_served, hold_left, stall_left;

  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("local_variance_fractal_dimension_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] log2_fix(logic [31:0] x);
    int          top;
    logic [63:0] m;
    logic [15:0] frac;
    top  = 0;
    frac = '0;
    for (int b = 0; b < 32; b++) if (x[b]) top = b;
    m = 64'(x) << (31 - top);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return {top[15:0], frac};
  endfunction

  task automatic window_variance(input int unsigned c, r, rad, w, h,
                                 output int unsigned vr [3]);
    int unsigned x0, y0, x1, y1, cnt;
    int unsigned acc [3];
    int unsigned avg [3];
    int          d;
    logic [23:0] p;
    x0 = c > rad ? c - rad : 0;
    y0 = r > rad ? r - rad : 0;
    x1 = (c + rad < w) ? c + rad : w;
    y1 = (r + rad < h) ? r + rad : h;
    cnt = (x1 - x0) * (y1 - y0);
    acc = '{0, 0, 0};
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = x0; x < x1; x++) begin
        p = pixels[y * STORE_W + x];
        for (int k = 0; k < 3; k++) acc[k] += (p >> (16 - 8 * k)) & 24'hff;
      end
    for (int k = 0; k < 3; k++) begin
      avg[k] = acc[k] / cnt;
      acc[k] = 0;
    end
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = x0; x < x1; x++) begin
        p = pixels[y * STORE_W + x];
        for (int k = 0; k < 3; k++) begin
          d = int'((p >> (16 - 8 * k)) & 24'hff) - int'(avg[k]);
          acc[k] += d * d;
        end
      end
    for (int k = 0; k < 3; k++) vr[k] = acc[k] / cnt;
  endtask

  task automatic predict_dimension(input int unsigned c, r, output result_t res);
    int unsigned w, h, d1, d2;
    int unsigned v1 [3];
    int unsigned v2 [3];
    longint      den, num, q;
    logic signed [15:0] dim [3];
    logic        und [3];
    w = clamp_u(img_w, 1, STORE_W);
    h = clamp_u(img_h, 1, STORE_H);
    if (c >= w || r >= h) begin
      res = '{dim_red: 0, dim_green: 0, dim_blue: 0,
              undef_red: 1, undef_green: 1, undef_blue: 1};
      return;
    end
    d1 = clamp_u(small_rad, 1, RADIUS_MAX);
    d2 = clamp_u(large_rad, 1, RADIUS_MAX);
    window_variance(c, r, d1, w, h, v1);
    window_variance(c, r, d2, w, h, v2);
    den = longint'(log2_fix(d2)) - longint'(log2_fix(d1));
    for (int k = 0; k < 3; k++) begin
      if (den == 0 || v1[k] == 0 || v2[k] == 0) begin
        dim[k] = '0;
        und[k] = 1'b1;
      end else begin
        num = longint'(log2_fix(v2[k])) - longint'(log2_fix(v1[k]));
        q   = (num * 4096) / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        dim[k] = q[15:0];
        und[k] = 1'b0;
      end
    end
    res = '{dim_red: dim[0], dim_green: dim[1], dim_blue: dim[2],
            undef_red: und[0], undef_green: und[1], undef_blue: und[2]};
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(200, 20);
  endfunction

  task automatic send_beat(input item_t b);
    result_t res;
    int      gap;
    item       <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (b.mode == MODE_WRITE) begin
      pixels[b.row * STORE_W + b.col]    = {b.red, b.green, b.blue};
      pixel_set[b.row * STORE_W + b.col] = 1'b1;
    end else begin
      predict_dimension(b.col, b.row, res);
      pending_dims.push_back(res);
    end
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_pixel(input int c, r, input logic [23:0] rgb);
    send_beat('{mode: MODE_WRITE, col: c[7:0], row: r[7:0],
                red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0]});
  endtask

  function automatic logic [7:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // fill any unwritten pixel that the larger window of a query would read
  task automatic cover_window(input int c, r);
    int unsigned w, h, rad, x0, y0, x1, y1;
    w   = clamp_u(img_w, 1, STORE_W);
    h   = clamp_u(img_h, 1, STORE_H);
    rad = clamp_u(small_rad, 1, RADIUS_MAX);
    if (clamp_u(large_rad, 1, RADIUS_MAX) > rad) rad = clamp_u(large_rad, 1, RADIUS_MAX);
    if (c >= w || r >= h) return;
    x0 = c > rad ? c - rad : 0;
    y0 = r > rad ? r - rad : 0;
    x1 = (c + rad < w) ? c + rad : w;
    y1 = (r + rad < h) ? r + rad : h;
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = x0; x < x1; x++)
        if (!pixel_set[y * STORE_W + x])
          write_pixel(x, y, {pick_sample(), pick_sample(), pick_sample()});
  endtask

  task automatic query_at(input int c, r);
    cover_window(c, r);
    send_beat('{mode: MODE_QUERY, col: c[7:0], row: r[7:0],
                red: 8'($urandom_range(255)), green: 8'($urandom_range(255)),
                blue: 8'($urandom_range(255))});
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_dims.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SMALL_RADIUS: small_rad = val[4:0];
      REG_LARGE_RADIUS: large_rad = val[4:0];
      REG_IMAGE_WIDTH:  img_w     = val;
      REG_IMAGE_HEIGHT: img_h     = val;
    endcase
  endtask

  task automatic set_config(input logic [8:0] s, l, w, h);
    write_reg(REG_SMALL_RADIUS, s);
    write_reg(REG_LARGE_RADIUS, l);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_dims.size() == 0) begin
        report_mismatch("result beats", 1, 0);
      end else begin
        want = pending_dims.pop_front();
        if (result.dim_red !== want.dim_red)
          report_mismatch("dim_red", result.dim_red, want.dim_red);
        if (result.dim_green !== want.dim_green)
          report_mismatch("dim_green", result.dim_green, want.dim_green);
        if (result.dim_blue !== want.dim_blue)
          report_mismatch("dim_blue", result.dim_blue, want.dim_blue);
        if (result.undef_red !== want.undef_red)
          report_mismatch("undef_red", result.undef_red, want.undef_red);
        if (result.undef_green !== want.undef_green)
          report_mismatch("undef_green", result.undef_green, want.undef_green);
        if (result.undef_blue !== want.undef_blue)
          report_mismatch("undef_blue", result.undef_blue, want.undef_blue);
      end
    end
  end

  always @(posedge clk) begin
    int r;
    if (hold_ticket != hold_served) begin
      hold_served  <= hold_ticket;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      r = $urandom_range(99);
      if (r >= 97) stall_left <= $urandom_range(300, 30);
      else if (r >= 80) stall_left <= $urandom_range(4, 1);
    end
  end

  task automatic test_default_corner();
    query_at(0, 0);
  endtask

  task automatic test_flat_region();
    set_config(9'd1, 9'd4, 9'd4, 9'd4);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++) write_pixel(x, y, 24'h80_80_80);
    query_at(0, 0);
    query_at(3, 3);
    write_pixel(2, 2, 24'hff_00_80);
    write_pixel(1, 3, 24'h00_ff_80);
    query_at(2, 2);
    query_at(3, 2);
  endtask

  task automatic test_radius_clamp();
    set_config(9'd5, 9'd5, 9'd8, 9'd8);
    query_at(7, 7);
    set_config(9'd0, 9'd31, 9'd8, 9'd8);
    query_at(4, 4);
    set_config(9'd16, 9'd1, 9'd8, 9'd8);
    query_at(5, 2);
    set_config(9'd17, 9'd16, 9'd8, 9'd8);
    query_at(0, 7);
  endtask

  task automatic test_outside_image();
    set_config(9'd1, 9'd2, 9'd0, 9'd300);
    query_at(1, 0);
    query_at(0, 255);
    query_at(255, 128);
    set_config(9'd2, 9'd3, 9'd511, 9'd4);
    query_at(200, 4);
    query_at(255, 3);
  endtask

  task automatic test_backpressure();
    set_config(9'd1, 9'd3, 9'd8, 9'd8);
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++)
        if (!pixel_set[y * STORE_W + x])
          write_pixel(x, y, {pick_sample(), pick_sample(), pick_sample()});
    wait_drained();
    calm = 1'b1;
    hold_ticket++;
    for (int i = 0; i < 5; i++) query_at($urandom_range(7), $urandom_range(7));
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    int c, r, w, h;
    for (int phase = 0; phase < 6; phase++) begin
      w = $urandom_range(8, 4);
      h = $urandom_range(8, 4);
      set_config(9'($urandom_range(31)), 9'($urandom_range(31)), 9'(w), 9'(h));
      calm = (phase == 2);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(99) < 40) begin
          c = $urandom_range(99) < 70 ? $urandom_range(w - 1) : $urandom_range(255);
          r = $urandom_range(99) < 70 ? $urandom_range(h - 1) : $urandom_range(255);
          write_pixel(c, r, {pick_sample(), pick_sample(), pick_sample()});
        end else begin
          c = $urandom_range(99) < 85 ? $urandom_range(w - 1) : $urandom_range(255);
          r = $urandom_range(99) < 85 ? $urandom_range(h - 1) : $urandom_range(255);
          query_at(c, r);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    errors      = 0;
    cycles      = 0;
    calm        = 1'b0;
    hold_ticket = 0;
    hold_served = 0;
    hold_left   = 0;
    stall_left  = 0;
    small_rad   = 5'd2;
    large_rad   = 5'd8;
    img_w       = 9'd256;
    img_h       = 9'd256;
    for (int i = 0; i < STORE_W * STORE_H; i++) pixel_set[i] = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_corner();
    test_flat_region();
    test_radius_clamp();
    test_outside_image();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (errors == 0) begin
      $display("local_variance_fractal_dimension_tb: done, clean");
    end else begin
      $display("local_variance_fractal_dimension_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== local_variance_fractal_dimension.f =====
rtl/lvfd_pkg.sv
rtl/lvfd_store.sv
rtl/lvfd_div.sv
rtl/lvfd_log2.sv
rtl/local_variance_fractal_dimension.sv
tb/sv/local_variance_fractal_dimension_tb.sv
